// File: rtl/pct_pkg.sv
`default_nettype none
package pct_pkg;

  // Polygon storage
  localparam int MaxVertices = 32;
  localparam int AddrW       = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CntW        = $clog2(MaxVertices + 1);

  // Far end of the horizontal ray cast by a point query
  localparam int RayFarX     = 65536;

  // Input coordinate width, working coordinate width and product widths
  localparam int InW         = 16;
  localparam int CoordW      = $clog2(RayFarX + 1) + 1;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int VtxW        = 2 * InW;

  // Configuration register file
  localparam int PAddrW      = 3;
  localparam int CfgIdxBit   = 2;
  localparam int VcountW     = 6;

  // Operation codes
  localparam logic [1:0] OpWrite   = 2'd0;
  localparam logic [1:0] OpPoint   = 2'd1;
  localparam logic [1:0] OpSegment = 2'd2;

  // Query kinds on the result
  localparam logic KindPoint   = 1'b0;
  localparam logic KindSegment = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  // Orientation triple fed to the shared unit
  typedef struct packed {
    point_t p;
    point_t q;
    point_t r;
  } orient_req_t;

  // Sign of an orientation: each of negative, zero, positive has its own code
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage
`default_nettype wire

// File: rtl/polygon_crossing_test_top.sv
`default_nettype none
// A query walks the n vertices in use (n clamped to 32) and then strobes its result;
// with n of 0 it strobes a miss straight from idle, without walking any edge.
// Throughput: one orientation a cycle through the shared multiplier unit while
// an edge is tested, four per edge and then an evaluation step; writes are taken in idle.
// busy stays high for the whole walk; the result is a one-cycle strobe on done_o.
// Reset clears vertex_count and the sequencer; vertex slots are undefined until written.
module polygon_crossing_test_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op_i,
  input  wire logic [4:0]                    vertex_index_i,
  input  wire logic signed [15:0]            a_x_i,
  input  wire logic signed [15:0]            a_y_i,
  input  wire logic signed [15:0]            b_x_i,
  input  wire logic signed [15:0]            b_y_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic                               query_kind_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pct_pkg::PAddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import pct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREV = 3'd1;
  localparam logic [2:0] S_CUR  = 3'd2;
  localparam logic [2:0] S_ORI  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [1:0]         ph_q, ph_d;
  logic [VcountW-1:0] vcount_q;
  logic [CntW-1:0]    n_used;
  logic [CntW-1:0]    left_q, left_d;
  logic [AddrW-1:0]   rd_idx_q, rd_idx_d, rd_next, raddr;
  logic               acc_q, acc_d, kind_q, kind_d;
  logic               done_q, done_d, hit_q, hit_d, qkind_q, qkind_d;
  point_t             a_q, a_d, b_q, b_d, prev_q, prev_d, cur_q, cur_d, rd_pt;
  sign_t              s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, sgn;
  orient_req_t        req;
  logic               accept, cfg_wr, ram_we, edge_hit;
  logic [VtxW-1:0]    rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = paddr[CfgIdxBit] ? 32'd0 : {{(32-VcountW){1'b0}}, vcount_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_wr && !paddr[CfgIdxBit]) begin
      vcount_q <= pwdata[VcountW-1:0];
    end
  end

  assign n_used = (32'(vcount_q) > MaxVertices) ? CntW'(MaxVertices) : CntW'(vcount_q);

  // Vertex store, y in the upper half
  assign accept = start & ~busy;
  assign ram_we = accept && (op_i == OpWrite) && (32'(vertex_index_i) < MaxVertices);

  pct_ram #(
    .Width(VtxW),
    .Depth(MaxVertices)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(vertex_index_i)),
    .wdata_i({a_y_i, a_x_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_pt.x = CoordW'(signed'(rdata[InW-1:0]));
  assign rd_pt.y = CoordW'(signed'(rdata[VtxW-1:InW]));

  // Next vertex slot, wrapping to slot 0 after the last one in use
  assign rd_next = (({1'b0, rd_idx_q} + 1'b1) == (AddrW+1)'(n_used)) ? '0 : rd_idx_q + 1'b1;

  // Orientation operands per phase
  always_comb begin
    case (ph_q)
      2'd0:    req = '{p: a_q,    q: b_q,   r: prev_q};
      2'd1:    req = '{p: a_q,    q: b_q,   r: cur_q};
      2'd2:    req = '{p: prev_q, q: cur_q, r: a_q};
      default: req = '{p: prev_q, q: cur_q, r: b_q};
    endcase
  end

  pct_orient u_orient (
    .clk_i (clk_i),
    .req_i (req),
    .sign_o(sgn)
  );

  assign edge_hit = (s1_q != s2_q) && (s3_q != sgn);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    left_d   = left_q;
    rd_idx_d = rd_idx_q;
    acc_d    = acc_q;
    kind_d   = kind_q;
    a_d      = a_q;
    b_d      = b_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    s3_d     = s3_q;
    done_d   = 1'b0;
    hit_d    = hit_q;
    qkind_d  = qkind_q;
    raddr    = rd_idx_q;
    case (state_q)
      S_IDLE: begin
        raddr = '0;
        if (accept && (op_i == OpPoint || op_i == OpSegment)) begin
          kind_d   = (op_i == OpSegment) ? KindSegment : KindPoint;
          a_d.x    = CoordW'(a_x_i);
          a_d.y    = CoordW'(a_y_i);
          b_d.x    = (op_i == OpSegment) ? CoordW'(b_x_i) : CoordW'(RayFarX);
          b_d.y    = (op_i == OpSegment) ? CoordW'(b_y_i) : CoordW'(a_y_i);
          rd_idx_d = '0;
          left_d   = n_used;
          acc_d    = 1'b0;
          if (n_used == '0) begin
            done_d  = 1'b1;
            hit_d   = 1'b0;
            qkind_d = (op_i == OpSegment) ? KindSegment : KindPoint;
          end else begin
            state_d = S_PREV;
          end
        end
      end
      S_PREV: begin
        prev_d   = rd_pt;
        raddr    = rd_next;
        rd_idx_d = rd_next;
        state_d  = S_CUR;
      end
      S_CUR: begin
        cur_d   = rd_pt;
        ph_d    = 2'd0;
        state_d = S_ORI;
      end
      S_ORI: begin
        case (ph_q)
          2'd1:    s1_d = sgn;
          2'd2:    s2_d = sgn;
          2'd3:    s3_d = sgn;
          default: ;
        endcase
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          // Fetch the following vertex while the last orientation settles
          raddr    = rd_next;
          rd_idx_d = rd_next;
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        acc_d  = (kind_q == KindSegment) ? (acc_q | edge_hit) : (acc_q ^ edge_hit);
        left_d = left_q - 1'b1;
        if (left_q == CntW'(1)) begin
          done_d  = 1'b1;
          hit_d   = (kind_q == KindSegment) ? (acc_q | edge_hit) : (acc_q ^ edge_hit);
          qkind_d = kind_q;
          state_d = S_IDLE;
        end else begin
          prev_d  = cur_q;
          cur_d   = rd_pt;
          ph_d    = 2'd0;
          state_d = S_ORI;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      left_q  <= left_d;
      done_q  <= done_d;
    end
  end

  // Working data and result beat
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    acc_q    <= acc_d;
    kind_q   <= kind_d;
    a_q      <= a_d;
    b_q      <= b_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    s1_q     <= s1_d;
    s2_q     <= s2_d;
    s3_q     <= s3_d;
    hit_q    <= hit_d;
    qkind_q  <= qkind_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign query_kind_o = qkind_q;

endmodule
`default_nettype wire

// File: rtl/pct_ram.sv
`default_nettype none
module pct_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic      [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/pct_orient.sv
`default_nettype none
module pct_orient (
  input  wire logic                 clk_i,
  input  wire pct_pkg::orient_req_t req_i,
  output pct_pkg::sign_t            sign_o
);
  import pct_pkg::*;

  logic signed [DiffW-1:0] dqy, drx, dry, dqx;
  logic signed [ProdW-1:0] prod_a_d, prod_b_d;
  logic signed [ProdW-1:0] prod_a_q, prod_b_q;
  logic signed [ProdW:0]   cross_diff;

  // Coordinate differences, one bit wider than the coordinates
  assign dqy = {req_i.q.y[CoordW-1], req_i.q.y} - {req_i.p.y[CoordW-1], req_i.p.y};
  assign drx = {req_i.r.x[CoordW-1], req_i.r.x} - {req_i.p.x[CoordW-1], req_i.p.x};
  assign dry = {req_i.r.y[CoordW-1], req_i.r.y} - {req_i.p.y[CoordW-1], req_i.p.y};
  assign dqx = {req_i.q.x[CoordW-1], req_i.q.x} - {req_i.p.x[CoordW-1], req_i.p.x};

  assign prod_a_d = dqy * drx;
  assign prod_b_d = dry * dqx;

  // Register both products
  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
  end

  // Take the sign of the cross product from the registered products
  assign cross_diff  = {prod_a_q[ProdW-1], prod_a_q} - {prod_b_q[ProdW-1], prod_b_q};
  assign sign_o.neg  = cross_diff[ProdW];
  assign sign_o.zero = (cross_diff == '0);

endmodule
`default_nettype wire
